@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define EFG_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Next-cycle implication: ante implies cons
`define EFG_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/efg_pkg.sv @@
// ---------------------------------------------------------------------------
// efg_pkg
// Shared sizes, operation and status codes, cell types and the wait
// condition of the event-flags group.
// ---------------------------------------------------------------------------
package efg_pkg;

  // Number of waiter slots, one cell each
  localparam int MAX_WAITERS = 8;
  // Width of the occupied-slot counter
  localparam int TOTAL_W     = $clog2(MAX_WAITERS + 1);

  // Operation codes
  localparam logic [2:0] FUNC_SET    = 3'd0;
  localparam logic [2:0] FUNC_CLEAR  = 3'd1;
  localparam logic [2:0] FUNC_WAIT   = 3'd2;
  localparam logic [2:0] FUNC_UNWAIT = 3'd3;
  localparam logic [2:0] FUNC_DELETE = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_NOT_WAITING = 2'd2;

  // One pending notification travelling down the cell chain
  typedef struct packed {
    logic        vld;
    logic [31:0] thr;
    logic [31:0] post;
  } note_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic load;   // capture own notification for a set
    logic shift;  // take the neighbour's notification
    logic wr;     // write the selected slot (wait)
    logic rel;    // free the selected slot (unwait)
    logic clr;    // free every slot (delete)
  } cell_ctl_t;

  // Any mode: some wanted bit present. All mode: every wanted bit present.
  function automatic logic cond_holds(input logic [31:0] flags,
                                      input logic [31:0] want,
                                      input logic        all_mode);
    logic [31:0] hit;
    hit = flags & want;
    if (all_mode) begin
      return hit == want;
    end
    return hit != 32'd0;
  endfunction

endpackage

@@ rtl/event_flags_group_waiters_unit.sv @@
// ---------------------------------------------------------------------------
// event_flags_group_waiters_unit
// Event-flags group with a row of waiter-slot cells: set, clear, wait,
// unwait and delete, each closed by one status beat.
// ---------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  input    | start & !busy           | in_func, in_flag_bits, in_wait_all,
//           |                         | in_thread_id, in_wake_bits
//  result   | out_strobe, one cycle   | out_is_notify .. out_last
//
//  Clear, unwait, delete, unknown codes and a wait that notifies nobody
//  (full table included) go straight to the status beat; a wait that
//  notifies first emits its own notification. A set scans the cell chain
//  up to the highest slot that notifies: notifications leave the cell
//  chain one slot per cycle from cell 0.
//  Synchronous active-low reset frees every slot and zeroes the flags.
//  Results cannot be held off; busy stays high until the status beat.
// ---------------------------------------------------------------------------
module event_flags_group_waiters_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_flag_bits,
  input  logic        in_wait_all,
  input  logic [31:0] in_thread_id,
  input  logic [31:0] in_wake_bits,
  output logic        out_strobe,
  output logic        out_is_notify,
  output logic [31:0] out_target_thread,
  output logic [31:0] out_posted_bits,
  output logic [31:0] out_flags_now,
  output logic [1:0]  out_status,
  output logic [3:0]  out_waiters_now,
  output logic        out_last
);
  import efg_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WNOTE, S_STAT} state_t;

  state_t               state_r;
  logic [31:0]          flags_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [1:0]           status_r;
  logic [31:0]          wn_thr_r;
  logic [31:0]          wn_post_r;

  logic                 out_strobe_r;
  logic                 out_is_notify_r;
  logic [31:0]          out_target_thread_r;
  logic [31:0]          out_posted_bits_r;
  logic [31:0]          out_flags_now_r;
  logic [1:0]           out_status_r;
  logic [3:0]           out_waiters_now_r;
  logic                 out_last_r;

  logic                   accept;
  logic [MAX_WAITERS-1:0] match_v;
  logic [MAX_WAITERS-1:0] free_v;
  logic [MAX_WAITERS-1:0] free_first;
  logic [MAX_WAITERS-1:0] wr_sel;
  logic [MAX_WAITERS-1:0] sel_v;
  logic [MAX_WAITERS-1:0] chain_vld;
  logic                   any_match;
  logic                   slot_ok;
  logic                   wait_hit;
  logic                   rest_vld;
  logic [31:0]            cond_flags;
  cell_ctl_t              ctl;
  note_t                  chain [0:MAX_WAITERS];

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Slot selection: the thread's own slot wins, else the lowest free one
  assign any_match  = |match_v;
  assign free_first = free_v & ((~free_v) + MAX_WAITERS'(1));
  assign slot_ok    = any_match || (|free_v);
  assign wr_sel     = any_match ? match_v : free_first;
  assign sel_v      = (in_func == FUNC_WAIT) ? wr_sel : match_v;

  assign cond_flags = flags_r | in_flag_bits;
  assign wait_hit   = cond_holds(flags_r, in_flag_bits, in_wait_all);

  // Broadcast commands
  always_comb begin
    ctl.load  = accept && (in_func == FUNC_SET);
    ctl.shift = (state_r == S_SCAN);
    ctl.wr    = accept && (in_func == FUNC_WAIT) && slot_ok;
    ctl.rel   = accept && (in_func == FUNC_UNWAIT);
    ctl.clr   = accept && (in_func == FUNC_DELETE);
  end

  // Row of slot cells; the chain drains towards cell 0
  assign chain[MAX_WAITERS] = '0;

  for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
    efg_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl_i        (ctl),
      .sel_i        (sel_v[i]),
      .cond_flags_i (cond_flags),
      .tid_i        (in_thread_id),
      .want_i       (in_flag_bits),
      .all_i        (in_wait_all),
      .post_i       (in_wake_bits),
      .up_i         (chain[i+1]),
      .note_o       (chain[i]),
      .match_o      (match_v[i]),
      .free_o       (free_v[i])
    );
    assign chain_vld[i] = chain[i].vld;
  end

  // Anything left behind the head after this shift
  assign rest_vld = |(chain_vld >> 1);

  // Hold the payload of a wait's immediate notification
  always_ff @(posedge clk) begin
    if (accept) begin
      wn_thr_r  <= in_thread_id;
      wn_post_r <= in_wake_bits;
    end
  end

  // Sequencer, group state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= S_IDLE;
      flags_r             <= 32'd0;
      total_r             <= '0;
      status_r            <= ST_OK;
      out_strobe_r        <= 1'b0;
      out_is_notify_r     <= 1'b0;
      out_target_thread_r <= 32'd0;
      out_posted_bits_r   <= 32'd0;
      out_flags_now_r     <= 32'd0;
      out_status_r        <= ST_OK;
      out_waiters_now_r   <= 4'd0;
      out_last_r          <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          out_strobe_r <= 1'b0;
          if (accept) begin
            case (in_func)
              FUNC_SET: begin
                flags_r  <= flags_r | in_flag_bits;
                status_r <= ST_OK;
                state_r  <= S_SCAN;
              end
              FUNC_CLEAR: begin
                flags_r  <= flags_r & ~in_flag_bits;
                status_r <= ST_OK;
                state_r  <= S_STAT;
              end
              FUNC_WAIT: begin
                if (!slot_ok) begin
                  status_r <= ST_FULL;
                  state_r  <= S_STAT;
                end else begin
                  status_r <= ST_OK;
                  if (!any_match) begin
                    total_r <= total_r + TOTAL_W'(1);
                  end
                  state_r <= wait_hit ? S_WNOTE : S_STAT;
                end
              end
              FUNC_UNWAIT: begin
                if (any_match) begin
                  total_r  <= total_r - TOTAL_W'(1);
                  status_r <= ST_OK;
                end else begin
                  status_r <= ST_NOT_WAITING;
                end
                state_r <= S_STAT;
              end
              FUNC_DELETE: begin
                flags_r  <= 32'd0;
                total_r  <= '0;
                status_r <= ST_OK;
                state_r  <= S_STAT;
              end
              default: begin
                status_r <= ST_OK;
                state_r  <= S_STAT;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Emit the head cell's notification, drop out once the chain is dry
          out_strobe_r <= chain[0].vld;
          if (chain[0].vld) begin
            out_is_notify_r     <= 1'b1;
            out_target_thread_r <= chain[0].thr;
            out_posted_bits_r   <= chain[0].post;
            out_flags_now_r     <= flags_r;
            out_status_r        <= ST_OK;
            out_waiters_now_r   <= 4'(total_r);
            out_last_r          <= 1'b0;
          end
          if (!rest_vld) begin
            state_r <= S_STAT;
          end
        end
        S_WNOTE: begin
          out_strobe_r        <= 1'b1;
          out_is_notify_r     <= 1'b1;
          out_target_thread_r <= wn_thr_r;
          out_posted_bits_r   <= wn_post_r;
          out_flags_now_r     <= flags_r;
          out_status_r        <= ST_OK;
          out_waiters_now_r   <= 4'(total_r);
          out_last_r          <= 1'b0;
          state_r             <= S_STAT;
        end
        S_STAT: begin
          out_strobe_r        <= 1'b1;
          out_is_notify_r     <= 1'b0;
          out_target_thread_r <= 32'd0;
          out_posted_bits_r   <= 32'd0;
          out_flags_now_r     <= flags_r;
          out_status_r        <= status_r;
          out_waiters_now_r   <= 4'(total_r);
          out_last_r          <= 1'b1;
          state_r             <= S_IDLE;
        end
        default: begin
          out_strobe_r <= 1'b0;
          state_r      <= S_IDLE;
        end
      endcase
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_is_notify     = out_is_notify_r;
  assign out_target_thread = out_target_thread_r;
  assign out_posted_bits   = out_posted_bits_r;
  assign out_flags_now     = out_flags_now_r;
  assign out_status        = out_status_r;
  assign out_waiters_now   = out_waiters_now_r;
  assign out_last          = out_last_r;

endmodule

@@ rtl/efg_cell.sv @@
// ---------------------------------------------------------------------------
// efg_cell
// One waiter slot: holds thread, mask, mode and post bits, compares the
// thread id locally and carries one stage of the notification chain.
// ---------------------------------------------------------------------------
module efg_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  efg_pkg::cell_ctl_t ctl_i,
  input  logic              sel_i,
  input  logic [31:0]       cond_flags_i,
  input  logic [31:0]       tid_i,
  input  logic [31:0]       want_i,
  input  logic              all_i,
  input  logic [31:0]       post_i,
  input  efg_pkg::note_t    up_i,
  output efg_pkg::note_t    note_o,
  output logic              match_o,
  output logic              free_o
);
  import efg_pkg::*;

  logic        used_r, used_nxt;
  logic [31:0] thr_r;
  logic [31:0] want_r;
  logic        all_r;
  logic [31:0] post_r;

  logic        note_vld_r;
  logic [31:0] note_thr_r;
  logic [31:0] note_post_r;
  note_t       note_nxt;

  // Local compare against the thread of the incoming beat
  assign match_o = used_r && (thr_r == tid_i);
  assign free_o  = !used_r;

  // Occupancy update
  always_comb begin
    used_nxt = used_r;
    if (ctl_i.clr) begin
      used_nxt = 1'b0;
    end else if (ctl_i.wr && sel_i) begin
      used_nxt = 1'b1;
    end else if (ctl_i.rel && sel_i) begin
      used_nxt = 1'b0;
    end
  end

  // Capture own notification on a set, otherwise advance the chain
  always_comb begin
    note_nxt.vld  = note_vld_r;
    note_nxt.thr  = note_thr_r;
    note_nxt.post = note_post_r;
    if (ctl_i.load) begin
      note_nxt.vld  = used_r && cond_holds(cond_flags_i, want_r, all_r);
      note_nxt.thr  = thr_r;
      note_nxt.post = post_r;
    end else if (ctl_i.shift) begin
      note_nxt = up_i;
    end
  end

  // Control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= 1'b0;
      note_vld_r <= 1'b0;
    end else begin
      used_r     <= used_nxt;
      note_vld_r <= note_nxt.vld;
    end
  end

  // Slot contents and chain payload
  always_ff @(posedge clk) begin
    if (ctl_i.wr && sel_i) begin
      thr_r  <= tid_i;
      want_r <= want_i;
      all_r  <= all_i;
      post_r <= post_i;
    end
    note_thr_r  <= note_nxt.thr;
    note_post_r <= note_nxt.post;
  end

  assign note_o.vld  = note_vld_r;
  assign note_o.thr  = note_thr_r;
  assign note_o.post = note_post_r;

endmodule

@@ rtl/efg_checker.sv @@
// ---------------------------------------------------------------------------
// efg_checker
// Port-level checks of the event-flags group: beat framing and the link
// between busy and the closing status beat.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module efg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_is_notify,
  input logic [31:0] out_target_thread,
  input logic [31:0] out_posted_bits,
  input logic [1:0]  out_status,
  input logic        out_last
);
  import efg_pkg::*;

  logic acc_beat;
  logic last_beat;
  logic note_beat;
  logic stat_beat;
  logic note_ok;
  logic stat_blank;

  assign acc_beat   = start && !busy;
  assign last_beat  = out_strobe && out_last;
  assign note_beat  = out_strobe && out_is_notify;
  assign stat_beat  = out_strobe && !out_is_notify;
  assign note_ok    = (out_status == ST_OK) && !out_last && busy;
  assign stat_blank = (out_target_thread == 32'd0) && (out_posted_bits == 32'd0);

  // An accepted operation keeps the block busy until its status beat
  `EFG_ASSERT_NEXT(a_accept_busy, clk, rst_n, acc_beat, busy, "no busy after accept")

  // The closing beat is a status beat and frees the block
  `EFG_ASSERT(a_last_status, clk, rst_n, last_beat |-> !out_is_notify && !busy, "bad last beat")

  // Notifications carry ok status, are never last and precede the status beat
  `EFG_ASSERT(a_notify_shape, clk, rst_n, note_beat |-> note_ok, "bad notify beat")

  // Status beats name no thread and post nothing
  `EFG_ASSERT(a_status_zero, clk, rst_n, stat_beat |-> stat_blank, "status beat payload")

endmodule

bind event_flags_group_waiters_unit efg_checker u_efg_checker (.*);
